>>> design/rsc_pkg.sv
// ----------------------------------------------------------------------------
// RC stick conditioner package
// Shared types, command codes, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // Channel numbers, in the order of the input item.
  localparam logic [1:0] CH_ROLL     = 2'd0;
  localparam logic [1:0] CH_PITCH    = 2'd1;
  localparam logic [1:0] CH_YAW      = 2'd2;
  localparam logic [1:0] CH_THROTTLE = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_CALIBRATE_MODE = 3'd0;
  localparam logic [2:0] REG_BIAS_ENABLE    = 3'd1;
  localparam logic [2:0] REG_STICK_GAIN     = 3'd2;
  localparam logic [2:0] REG_MIN_THROTTLE   = 3'd3;
  localparam logic [2:0] REG_THROTTLE_BIAS  = 3'd4;
  localparam logic [2:0] REG_YAW_BIAS       = 3'd5;
  localparam logic [2:0] REG_PITCH_BIAS     = 3'd6;
  localparam logic [2:0] REG_ROLL_BIAS      = 3'd7;

  localparam int CMD_W = 20;

  // Calibration limits in microseconds.
  localparam int CAL_LOW  = 1400;
  localparam int CAL_HIGH = 1800;

  // Expo coefficients in Q.24.
  localparam logic [24:0] EXPO_C3 = 25'd30199;
  localparam logic [24:0] EXPO_C1 = 25'd29709094;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_MAP_MUL,
    CMD_DIV_START,
    CMD_MAP_DONE,
    CMD_SCL_MUL,
    CMD_SCL_FIN,
    CMD_EXP_SQ,
    CMD_EXP_CUBE,
    CMD_EXP_C3,
    CMD_EXP_C1,
    CMD_EXP_FIN,
    CMD_STORE,
    CMD_RESULT
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] ch;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  // Output span of each channel's linear map.
  function automatic logic [7:0] chan_span(logic [1:0] ch);
    logic [7:0] s;
    case (ch)
      CH_ROLL, CH_PITCH: s = 8'd40;
      CH_YAW:            s = 8'd180;
      default:           s = 8'd75;
    endcase
    return s;
  endfunction

  // Output minimum of each channel's linear map.
  function automatic logic signed [7:0] chan_outmin(logic [1:0] ch);
    logic signed [7:0] m;
    case (ch)
      CH_ROLL, CH_PITCH: m = -8'sd20;
      CH_YAW:            m = -8'sd90;
      default:           m = 8'sd5;
    endcase
    return m;
  endfunction

endpackage

>>> design/rsc_div.sv
// ----------------------------------------------------------------------------
// RC stick conditioner divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsc_div #(
  parameter int DW = 29,
  parameter int VW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quo_o,
  output logic          done_o
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_q, dvd_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [VW:0]     rem_q, rem_d;
  logic [VW-1:0]   den_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [VW:0]     trial;
  logic            fits;

  always_comb begin
    trial  = {rem_q[VW-1:0], dvd_q[DW-1]};
    fits   = (trial >= {1'b0, den_q});
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      quo_d  = '0;
      rem_d  = '0;
      cnt_d  = CNTW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DW-2:0], 1'b0};
      rem_d = fits ? (trial - {1'b0, den_q}) : trial;
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

>>> design/rsc_datapath.sv
// ----------------------------------------------------------------------------
// RC stick conditioner datapath
// Calibration extremes, shared multiplier and divider, expo and trims.
// ----------------------------------------------------------------------------
module rsc_datapath import rsc_pkg::*; #(
  parameter int PW = 12,
  parameter int FB = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_t                    ctrl_i,
  output status_t                  status_o,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_index_i,
  input  logic [19:0]              cfg_data_i,
  input  logic [PW-1:0]            roll_pulse_i,
  input  logic [PW-1:0]            pitch_pulse_i,
  input  logic [PW-1:0]            yaw_pulse_i,
  input  logic [PW-1:0]            throttle_pulse_i,
  output logic signed [CMD_W-1:0]  roll_cmd_o,
  output logic signed [CMD_W-1:0]  pitch_cmd_o,
  output logic signed [CMD_W-1:0]  yaw_cmd_o,
  output logic signed [CMD_W-1:0]  throttle_cmd_o,
  output logic                     still_changing_o,
  output logic                     calibrated_o,
  output logic                     flying_o,
  output logic                     arm_request_o,
  output logic                     disarm_request_o
);

  localparam int DW  = PW + FB + 9;
  localparam int MW  = DW + 2;
  localparam int XW  = (MW > 32) ? MW : 32;
  localparam int AW  = 32;
  localparam int BW  = 25;
  localparam int PRW = AW + BW;
  localparam int SW  = MW + 2;
  localparam int GW  = 48;

  // Configuration registers.
  logic              calibrate_mode_q;
  logic              bias_enable_q;
  logic [11:0]       stick_gain_q;
  logic [14:0]       min_throttle_q;
  logic signed [19:0] throttle_bias_q, yaw_bias_q, pitch_bias_q, roll_bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calibrate_mode_q <= 1'b0;
      bias_enable_q    <= 1'b0;
      stick_gain_q     <= 12'd256;
      min_throttle_q   <= 15'd2560;
      throttle_bias_q  <= '0;
      yaw_bias_q       <= '0;
      pitch_bias_q     <= '0;
      roll_bias_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CALIBRATE_MODE: calibrate_mode_q <= cfg_data_i[0];
        REG_BIAS_ENABLE:    bias_enable_q    <= cfg_data_i[0];
        REG_STICK_GAIN:     stick_gain_q     <= cfg_data_i[11:0];
        REG_MIN_THROTTLE:   min_throttle_q   <= cfg_data_i[14:0];
        REG_THROTTLE_BIAS:  throttle_bias_q  <= cfg_data_i;
        REG_YAW_BIAS:       yaw_bias_q       <= cfg_data_i;
        REG_PITCH_BIAS:     pitch_bias_q     <= cfg_data_i;
        REG_ROLL_BIAS:      roll_bias_q      <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // Captured pulses and calibration extremes.
  logic [PW-1:0] pulse_q [4];
  logic [PW-1:0] lo_q [4];
  logic [PW-1:0] hi_q [4];
  logic [PW-1:0] in_pulse [4];
  logic          changing_q;
  logic          changing;

  assign in_pulse[0] = roll_pulse_i;
  assign in_pulse[1] = pitch_pulse_i;
  assign in_pulse[2] = yaw_pulse_i;
  assign in_pulse[3] = throttle_pulse_i;

  always_comb begin
    changing = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (calibrate_mode_q && ((in_pulse[i] < lo_q[i]) || (in_pulse[i] > hi_q[i]))) begin
        changing = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        lo_q[i] <= '1;
        hi_q[i] <= '0;
      end
    end else if (ctrl_i.cmd == CMD_CAPTURE && calibrate_mode_q) begin
      for (int i = 0; i < 4; i++) begin
        if (in_pulse[i] < lo_q[i]) lo_q[i] <= in_pulse[i];
        if (in_pulse[i] > hi_q[i]) hi_q[i] <= in_pulse[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_CAPTURE) begin
      for (int i = 0; i < 4; i++) pulse_q[i] <= in_pulse[i];
      changing_q <= changing;
    end
  end

  // Current channel operands.
  logic [PW-1:0] cur_p, cur_lo, cur_hi;
  logic [PW-1:0] mag_diff, den;
  logic          diff_neg, empty;

  assign cur_p    = pulse_q[ctrl_i.ch];
  assign cur_lo   = lo_q[ctrl_i.ch];
  assign cur_hi   = hi_q[ctrl_i.ch];
  assign diff_neg = (cur_p < cur_lo);
  assign mag_diff = diff_neg ? (cur_lo - cur_p) : (cur_p - cur_lo);
  assign den      = cur_hi - cur_lo;
  assign empty    = (cur_hi <= cur_lo);

  // Working registers.
  logic [PRW-1:0]        prod_q;
  logic signed [MW-1:0]  val_q;
  logic                  neg_q, empty_q;
  logic [PW-1:0]         den_q;
  logic [20:0]           a_q;
  logic [23:0]           t3_q;
  logic signed [CMD_W-1:0] res_q [4];

  // Divider.
  logic [DW-1:0] dividend, quo;
  logic          div_done;

  assign dividend = DW'({prod_q[PW+7:0], {FB{1'b0}}}) + DW'(den_q >> 1);

  rsc_div #(.DW(DW), .VW(PW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctrl_i.cmd == CMD_DIV_START),
    .dividend_i(dividend),
    .divisor_i (den_q),
    .quo_o     (quo),
    .done_o    (div_done)
  );

  assign status_o.div_done = div_done;

  // Magnitude helpers and rounding of products.
  logic [XW-1:0]  val_mag;
  logic [30:0]    scl_in;
  logic [20:0]    expo_in;
  logic [PRW-1:0] prod_sh, prod_r8, prod_r24;
  logic [31:0]    a2c, a3c;
  logic [21:0]    scl_out;
  logic [24:0]    expo_sum;
  logic [21:0]    expo_out;

  always_comb begin
    val_mag  = val_q[MW-1] ? XW'(-val_q) : XW'(val_q);
    scl_in   = (val_mag > XW'(64'd1 << 30)) ? 31'(64'd1 << 30) : val_mag[30:0];
    expo_in  = (val_mag > XW'(64'd1 << 20)) ? 21'(64'd1 << 20) : val_mag[20:0];
    prod_sh  = prod_q >> FB;
    prod_r8  = (prod_q + PRW'(128)) >> 8;
    prod_r24 = (prod_q + PRW'(64'd1 << 23)) >> 24;
    a2c      = (prod_sh > PRW'(64'hFFFF_FFFF)) ? 32'hFFFF_FFFF : prod_sh[31:0];
    a3c      = (prod_sh > PRW'(64'd1 << 31)) ? 32'h8000_0000 : prod_sh[31:0];
    scl_out  = (prod_r8 > PRW'(64'd1 << 21)) ? 22'(64'd1 << 21) : prod_r8[21:0];
    expo_sum = 25'(t3_q) + 25'(prod_r24[23:0]);
    expo_out = (expo_sum > 25'(64'd1 << 21)) ? 22'(64'd1 << 21) : expo_sum[21:0];
  end

  // Shared multiplier with a registered product.
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic          mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (ctrl_i.cmd)
      CMD_MAP_MUL: begin
        mul_a = AW'(mag_diff);
        mul_b = BW'(chan_span(ctrl_i.ch));
      end
      CMD_SCL_MUL: begin
        mul_a = AW'(scl_in);
        mul_b = BW'(stick_gain_q);
      end
      CMD_EXP_SQ: begin
        mul_a = AW'(expo_in);
        mul_b = BW'(expo_in);
      end
      CMD_EXP_CUBE: begin
        mul_a = a2c;
        mul_b = BW'(a_q);
      end
      CMD_EXP_C3: begin
        mul_a = a3c;
        mul_b = EXPO_C3;
      end
      CMD_EXP_C1: begin
        mul_a = AW'(a_q);
        mul_b = EXPO_C1;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= PRW'(mul_a) * PRW'(mul_b);
    end
  end

  // Map result, trims and saturation.
  logic signed [MW-1:0] q_signed, map_val, off;
  logic signed [20:0]   bias_sel;
  logic signed [SW-1:0] biased;
  logic signed [CMD_W-1:0] sat_val;

  always_comb begin
    q_signed = neg_q ? -$signed(MW'(quo)) : $signed(MW'(quo));
    off      = MW'(chan_outmin(ctrl_i.ch)) <<< FB;
    map_val  = empty_q ? '0 : (q_signed + off);
    case (ctrl_i.ch)
      CH_ROLL:  bias_sel = 21'(roll_bias_q);
      CH_PITCH: bias_sel = 21'(pitch_bias_q);
      CH_YAW:   bias_sel = 21'(yaw_bias_q);
      default:  bias_sel = 21'(throttle_bias_q) - (21'sd5 <<< FB);
    endcase
    biased = SW'(val_q) - (bias_enable_q ? SW'(bias_sel) : '0);
    if (biased > SW'(524287)) begin
      sat_val = 20'sd524287;
    end else if (biased < -SW'(524288)) begin
      sat_val = -20'sd524288;
    end else begin
      sat_val = biased[CMD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_MAP_MUL: begin
        neg_q   <= diff_neg;
        empty_q <= empty;
        den_q   <= den;
      end
      CMD_MAP_DONE: val_q <= map_val;
      CMD_SCL_MUL:  neg_q <= val_q[MW-1];
      CMD_SCL_FIN:  val_q <= neg_q ? -$signed(MW'(scl_out)) : $signed(MW'(scl_out));
      CMD_EXP_SQ: begin
        neg_q <= val_q[MW-1];
        a_q   <= expo_in;
      end
      CMD_EXP_C1:   t3_q  <= prod_r24[23:0];
      CMD_EXP_FIN:  val_q <= neg_q ? -$signed(MW'(expo_out)) : $signed(MW'(expo_out));
      CMD_STORE:    res_q[ctrl_i.ch] <= sat_val;
      default: ;
    endcase
  end

  // Calibration flag, and flying flag and gestures on the saturated commands.
  logic                 cal;
  logic signed [GW-1:0] rs_one, roll_x, pitch_x, yaw_x, thr_x, mt_x;
  logic signed [GW-1:0] roll_abs, pitch_abs;
  logic                 arm, disarm, fly;

  always_comb begin
    cal = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (!((lo_q[i] < PW'(CAL_LOW)) && (hi_q[i] > PW'(CAL_HIGH)))) cal = 1'b0;
    end
    rs_one    = $signed(GW'(stick_gain_q)) <<< FB;
    roll_x    = GW'(res_q[0]);
    pitch_x   = GW'(res_q[1]);
    yaw_x     = GW'(res_q[2]);
    thr_x     = GW'(res_q[3]);
    mt_x      = $signed(GW'(min_throttle_q));
    roll_abs  = roll_x[GW-1] ? -roll_x : roll_x;
    pitch_abs = pitch_x[GW-1] ? -pitch_x : pitch_x;
    fly       = (thr_x > mt_x);
    arm       = (thr_x < mt_x) && ((yaw_x <<< 9) < -(rs_one * 17))
                && ((roll_x <<< 8) < -(rs_one * 19)) && ((pitch_x <<< 8) > (rs_one * 19));
    disarm    = (thr_x < mt_x) && ((yaw_x <<< 9) > (rs_one * 17))
                && ((roll_abs <<< 8) < (rs_one * 5)) && ((pitch_abs <<< 8) < (rs_one * 5));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_RESULT) begin
      roll_cmd_o       <= res_q[0];
      pitch_cmd_o      <= res_q[1];
      yaw_cmd_o        <= res_q[2];
      throttle_cmd_o   <= res_q[3];
      still_changing_o <= changing_q;
      calibrated_o     <= cal;
      flying_o         <= fly;
      arm_request_o    <= arm;
      disarm_request_o <= disarm;
    end
  end

endmodule

>>> design/rsc_ctrl.sv
// ----------------------------------------------------------------------------
// RC stick conditioner controller
// Sequences the four channels through the map, scale, expo and trim steps that each one needs.
// ----------------------------------------------------------------------------
module rsc_ctrl import rsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_MUL   = 13'b0000000000010,
    ST_DLOAD = 13'b0000000000100,
    ST_DIV   = 13'b0000000001000,
    ST_MAPD  = 13'b0000000010000,
    ST_SMUL  = 13'b0000000100000,
    ST_SFIN  = 13'b0000001000000,
    ST_ESQ   = 13'b0000010000000,
    ST_ECUBE = 13'b0000100000000,
    ST_EC3   = 13'b0001000000000,
    ST_EC1   = 13'b0010000000000,
    ST_EFIN  = 13'b0100000000000,
    ST_STORE = 13'b1000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] ch_q, ch_d;
  logic       out_valid_q, out_valid_d;
  logic       res_pend_q, res_pend_d;
  cmd_e       cmd;

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    res_pend_d  = res_pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd         = CMD_NONE;
    case (state_q)
      ST_IDLE: begin
        if (res_pend_q) begin
          if (!out_valid_q || !out_stall_i) begin
            cmd         = CMD_RESULT;
            out_valid_d = 1'b1;
            res_pend_d  = 1'b0;
          end
        end else if (in_valid_i) begin
          cmd     = CMD_CAPTURE;
          ch_d    = CH_ROLL;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd     = CMD_MAP_MUL;
        state_d = ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd     = CMD_DIV_START;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_MAPD;
      end
      ST_MAPD: begin
        cmd     = CMD_MAP_DONE;
        state_d = (ch_q == CH_THROTTLE) ? ST_STORE : ST_SMUL;
      end
      ST_SMUL: begin
        cmd     = CMD_SCL_MUL;
        state_d = ST_SFIN;
      end
      ST_SFIN: begin
        cmd     = CMD_SCL_FIN;
        state_d = (ch_q == CH_YAW) ? ST_STORE : ST_ESQ;
      end
      ST_ESQ: begin
        cmd     = CMD_EXP_SQ;
        state_d = ST_ECUBE;
      end
      ST_ECUBE: begin
        cmd     = CMD_EXP_CUBE;
        state_d = ST_EC3;
      end
      ST_EC3: begin
        cmd     = CMD_EXP_C3;
        state_d = ST_EC1;
      end
      ST_EC1: begin
        cmd     = CMD_EXP_C1;
        state_d = ST_EFIN;
      end
      ST_EFIN: begin
        cmd     = CMD_EXP_FIN;
        state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd = CMD_STORE;
        if (ch_q == CH_THROTTLE) begin
          res_pend_d = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= CH_ROLL;
      out_valid_q <= 1'b0;
      res_pend_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      res_pend_q  <= res_pend_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE) || res_pend_q;
  assign out_valid_o = out_valid_q;
  assign ctrl_o.cmd  = cmd;
  assign ctrl_o.ch   = ch_q;

endmodule

>>> design/rc_stick_conditioner.sv
// ----------------------------------------------------------------------------
// RC stick conditioner
// Turns one frame of four RC pulse widths into fixed-point stick commands.
// ----------------------------------------------------------------------------
// Each input item is one frame of roll, pitch, yaw and throttle pulse widths
// in microseconds, and each frame yields exactly one result item. The block
// works on one frame at a time, at a pace set mostly by the shared divider,
// which produces one quotient bit per cycle and serves the four channels in
// turn. A finished result sits in an output register, so the next frame is
// accepted while that result waits to be taken.
// While calibrate_mode is set, the lowest and highest pulse of every channel
// are tracked before the frame is mapped, and still_changing reports whether
// any extreme moved. Each channel is mapped linearly from its calibrated
// range (the map yields zero while the range is empty), roll, pitch and yaw
// are scaled by the stick gain register, roll and pitch pass the cubic expo,
// trims are subtracted when bias_enable is set, and every command is saturated
// to a signed 20-bit value with FRACTION_BITS fraction bits. The flying, arm
// and disarm flags are taken from the saturated commands. Configuration must
// only be written while no frame is in flight.
module rc_stick_conditioner import rsc_pkg::*; #(
  parameter int PULSE_WIDTH_BITS = 12,
  parameter int FRACTION_BITS    = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [19:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [PULSE_WIDTH_BITS-1:0] roll_pulse_i,
  input  logic [PULSE_WIDTH_BITS-1:0] pitch_pulse_i,
  input  logic [PULSE_WIDTH_BITS-1:0] yaw_pulse_i,
  input  logic [PULSE_WIDTH_BITS-1:0] throttle_pulse_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [CMD_W-1:0]     roll_cmd_o,
  output logic signed [CMD_W-1:0]     pitch_cmd_o,
  output logic signed [CMD_W-1:0]     yaw_cmd_o,
  output logic signed [CMD_W-1:0]     throttle_cmd_o,
  output logic                        still_changing_o,
  output logic                        calibrated_o,
  output logic                        flying_o,
  output logic                        arm_request_o,
  output logic                        disarm_request_o
);

  ctrl_t   ctrl;
  status_t status;

  // The controller walks each channel through its steps and owns the
  // handshakes; the datapath holds all values and the arithmetic units.
  rsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  rsc_datapath #(
    .PW(PULSE_WIDTH_BITS),
    .FB(FRACTION_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .roll_pulse_i    (roll_pulse_i),
    .pitch_pulse_i   (pitch_pulse_i),
    .yaw_pulse_i     (yaw_pulse_i),
    .throttle_pulse_i(throttle_pulse_i),
    .roll_cmd_o      (roll_cmd_o),
    .pitch_cmd_o     (pitch_cmd_o),
    .yaw_cmd_o       (yaw_cmd_o),
    .throttle_cmd_o  (throttle_cmd_o),
    .still_changing_o(still_changing_o),
    .calibrated_o    (calibrated_o),
    .flying_o        (flying_o),
    .arm_request_o   (arm_request_o),
    .disarm_request_o(disarm_request_o)
  );

endmodule
